>>> sv/ppmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_pkg
// shared types and constants of the pixel pedestal mean/rms block
// ----------------------------------------------------------------------------
package ppmr_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 28;
  localparam int SQ_W     = 44;
  localparam int FRM_W    = 13;
  localparam int PIX_W    = 17;
  localparam int CH_W     = 3;
  localparam int NCH_W    = 4;
  localparam int TOT_W    = 41;
  localparam int RES_W    = 24;
  localparam int PROD_W   = 57;
  localparam int X_W      = 48;
  localparam int DIV_DW   = 73;
  localparam int DIV_VW   = 25;
  localparam int CFG_W    = 17;
  localparam int CFG_IW   = 2;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int PIXEL_LIMIT = 65536;

  typedef enum logic [CFG_IW-1:0] {
    REG_FRAMES   = 2'd0,
    REG_PIXELS   = 2'd1,
    REG_CHANNELS = 2'd2,
    REG_UNUSED   = 2'd3
  } reg_index_t;

  // one finished pixel waiting for the back end
  typedef struct packed {
    logic [SUM_W-1:0] sample_sum;
    logic [SQ_W-1:0]  square_sum;
    logic [FRM_W-1:0] frames;
    logic [CH_W-1:0]  channel;
    logic [15:0]      pixel;
    logic             chan_done;
    logic [PIX_W-1:0] pixels;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL_A,
    B_MUL_B,
    B_DIV_MEAN,
    B_DIV_VAR,
    B_SQRT,
    B_DIV_AVG,
    B_OUT
  } back_state_t;

endpackage
`default_nettype wire

>>> sv/ppmr_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ppmr_div
  import ppmr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIV_DW-1:0] dividend,
  input  wire logic [DIV_VW-1:0] divisor,
  output logic                   done,
  output logic [DIV_DW-1:0]      quotient
);

  localparam int CNT_W = $clog2(DIV_DW + 1);

  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW-1:0] rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DIV_VW:0]   rem_shift;
  logic              fit;

  always_comb begin
    rem_shift = {rem_r, quo_r[DIV_DW-1]};
    fit       = rem_shift >= {1'b0, dvs_r};
    rem_nxt   = fit ? DIV_VW'(rem_shift - {1'b0, dvs_r}) : rem_shift[DIV_VW-1:0];
    quo_nxt   = {quo_r[DIV_DW-2:0], fit};
    cnt_nxt   = cnt_r - CNT_W'(1);
    busy_nxt  = busy_r && (cnt_r != CNT_W'(1));
    done_nxt  = busy_r && (cnt_r == CNT_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DIV_DW);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("divider counter ran out while busy");

endmodule
`default_nettype wire

>>> sv/ppmr_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_fifo
// short queue of finished pixels between front and back end
// ----------------------------------------------------------------------------
module ppmr_fifo
  import ppmr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire job_t   push_job,
  input  wire logic   pop,
  output job_t        head_job,
  output fifo_status_t status
);

  job_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_r, rd_r;
  logic [FIFO_AW:0]     count_r;
  logic                 do_push, do_pop;

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + FIFO_AW'(1);
      if (do_pop)  rd_r <= rd_r + FIFO_AW'(1);
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (FIFO_AW+1)'(1);
        2'b01:   count_r <= count_r - (FIFO_AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_job;
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue overfilled");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != (FIFO_AW+1)'(FIFO_DEPTH) && count_r != '0) |-> (wr_r != rd_r))
    else $error("queue pointers out of step");

endmodule
`default_nettype wire

>>> sv/ppmr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_front
// accumulates samples per pixel and hands finished pixels to the queue
// ----------------------------------------------------------------------------
module ppmr_front
  import ppmr_pkg::*;
#(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAMES   = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_wr_en,
  input  wire logic [CFG_IW-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]    cfg_data,
  input  wire logic                in_push,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire fifo_status_t        fifo_status,
  output logic                     in_full,
  output logic                     job_push,
  output job_t                     job
);

  logic [FRM_W-1:0] nf_cfg_r;
  logic [PIX_W-1:0] np_cfg_r;
  logic [NCH_W-1:0] nc_cfg_r;
  logic [FRM_W-1:0] nf;
  logic [PIX_W-1:0] np;
  logic [NCH_W-1:0] nc;

  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]  sq_r, sq_nxt;
  logic [FRM_W-1:0] frame_r;
  logic [PIX_W-1:0] pix_r;
  logic [CH_W-1:0]  chan_r;

  logic [SAMPLE_W-1:0] smask, s;
  logic                accept, last_frame, pix_last, chan_last;

  always_comb begin
    smask = SAMPLE_W'((17'd1 << SAMPLE_BITS) - 17'd1);
    s     = in_sample & smask;
    nf = (nf_cfg_r == '0) ? FRM_W'(1) :
         (nf_cfg_r > FRM_W'(MAX_FRAMES)) ? FRM_W'(MAX_FRAMES) : nf_cfg_r;
    np = (np_cfg_r == '0) ? PIX_W'(1) :
         (np_cfg_r > PIX_W'(PIXEL_LIMIT)) ? PIX_W'(PIXEL_LIMIT) : np_cfg_r;
    nc = (nc_cfg_r == '0) ? NCH_W'(1) :
         (nc_cfg_r > NCH_W'(MAX_CHANNELS)) ? NCH_W'(MAX_CHANNELS) : nc_cfg_r;
    sum_nxt    = sum_r + SUM_W'(s);
    sq_nxt     = sq_r + SQ_W'(s * s);
    last_frame = ({1'b0, frame_r} + (FRM_W+1)'(1)) >= {1'b0, nf};
    pix_last   = ({1'b0, pix_r} + (PIX_W+1)'(1)) >= {1'b0, np};
    chan_last  = ({1'b0, chan_r} + NCH_W'(1)) >= nc;
    in_full    = fifo_status.full;
    accept     = in_push && !fifo_status.full;
    job_push   = accept && last_frame;
    job.sample_sum = sum_nxt;
    job.square_sum = sq_nxt;
    job.frames     = frame_r + FRM_W'(1);
    job.channel    = chan_r;
    job.pixel      = pix_r[15:0];
    job.chan_done  = pix_last;
    job.pixels     = np;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_cfg_r <= FRM_W'(1);
      np_cfg_r <= PIX_W'(1);
      nc_cfg_r <= NCH_W'(1);
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_FRAMES:   nf_cfg_r <= cfg_data[FRM_W-1:0];
        REG_PIXELS:   np_cfg_r <= cfg_data[PIX_W-1:0];
        REG_CHANNELS: nc_cfg_r <= cfg_data[NCH_W-1:0];
        default:      nf_cfg_r <= nf_cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      sq_r    <= '0;
      frame_r <= '0;
      pix_r   <= '0;
      chan_r  <= '0;
    end else if (accept) begin
      if (last_frame) begin
        sum_r   <= '0;
        sq_r    <= '0;
        frame_r <= '0;
        if (pix_last) begin
          pix_r  <= '0;
          chan_r <= chan_last ? '0 : chan_r + CH_W'(1);
        end else begin
          pix_r <= pix_r + PIX_W'(1);
        end
      end else begin
        sum_r   <= sum_nxt;
        sq_r    <= sq_nxt;
        frame_r <= frame_r + FRM_W'(1);
      end
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !fifo_status.full) else $error("pixel pushed into full queue");
  a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r < FRM_W'(MAX_FRAMES)) else $error("frame counter past limit");

endmodule
`default_nettype wire

>>> sv/ppmr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppmr_back
// per-pixel mean, variance, square root and channel average; output register
// ----------------------------------------------------------------------------
module ppmr_back
  import ppmr_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire job_t          head_job,
  input  wire fifo_status_t  fifo_status,
  output logic               job_pop,
  output logic               out_empty,
  input  wire logic          out_pop,
  output logic [CH_W-1:0]    out_channel_index,
  output logic [15:0]        out_pixel_index,
  output logic [RES_W-1:0]   out_mean_value,
  output logic [RES_W-1:0]   out_rms_value,
  output logic               out_channel_done,
  output logic [RES_W-1:0]   out_channel_avg_rms
);

  back_state_t state_r, state_nxt;

  job_t              job_r;
  logic [PROD_W-1:0] acc_r, mcand_r, p1_r, v_r;
  logic [SUM_W-1:0]  mplier_r;
  logic [4:0]        cnt_r;
  logic [X_W-1:0]    sq_rem_r, sq_res_r, sq_bit_r;
  logic [RES_W-1:0]  mean_r, rms_r, avg_r;
  logic [TOT_W-1:0]  rms_total_r;
  logic              out_valid_r;

  logic [PROD_W-1:0] acc_add;
  logic [X_W-1:0]    sq_try, sq_res_next;
  logic              sq_fit, out_free;
  logic [RES_W-1:0]  rms_now;
  logic [TOT_W-1:0]  total_sum;
  logic [2*FRM_W-1:0] n_sq;

  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dividend, div_q;
  logic [DIV_VW-1:0] div_divisor;

  ppmr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    acc_add     = mplier_r[0] ? acc_r + mcand_r : acc_r;
    sq_try      = sq_res_r + sq_bit_r;
    sq_fit      = sq_rem_r >= sq_try;
    sq_res_next = sq_fit ? (sq_res_r >> 1) + sq_bit_r : sq_res_r >> 1;
    rms_now     = sq_res_next[RES_W-1:0];
    total_sum   = rms_total_r + TOT_W'(rms_now);
    n_sq        = job_r.frames * job_r.frames;
    out_free    = !out_valid_r || out_pop;
  end

  always_comb begin
    state_nxt    = state_r;
    job_pop      = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DIV_VW'(1);
    case (state_r)
      B_IDLE: begin
        if (!fifo_status.empty) begin
          job_pop   = 1'b1;
          state_nxt = B_MUL_A;
        end
      end
      B_MUL_A: begin
        if (cnt_r == '0) state_nxt = B_MUL_B;
      end
      B_MUL_B: begin
        if (cnt_r == '0) begin
          // mean = floor(256*sum/n)
          div_start    = 1'b1;
          div_dividend = DIV_DW'({job_r.sample_sum, 8'd0});
          div_divisor  = DIV_VW'(job_r.frames);
          state_nxt    = B_DIV_MEAN;
        end
      end
      B_DIV_MEAN: begin
        if (div_done) begin
          // variance scaled by 2^16: v*65536 / n^2
          div_start    = 1'b1;
          div_dividend = {v_r, 16'd0};
          div_divisor  = n_sq[DIV_VW-1:0];
          state_nxt    = B_DIV_VAR;
        end
      end
      B_DIV_VAR: begin
        if (div_done) state_nxt = B_SQRT;
      end
      B_SQRT: begin
        if (cnt_r == '0) begin
          if (job_r.chan_done) begin
            div_start    = 1'b1;
            div_dividend = DIV_DW'(total_sum);
            div_divisor  = DIV_VW'(job_r.pixels);
            state_nxt    = B_DIV_AVG;
          end else begin
            state_nxt = B_OUT;
          end
        end
      end
      B_DIV_AVG: begin
        if (div_done) state_nxt = B_OUT;
      end
      B_OUT: begin
        if (out_free) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rms_total_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == B_SQRT && cnt_r == '0) begin
        rms_total_r <= job_r.chan_done ? '0 : total_sum;
      end
      if (state_r == B_OUT && out_free) out_valid_r <= 1'b1;
      else if (out_pop)                 out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (!fifo_status.empty) begin
          job_r    <= head_job;
          acc_r    <= '0;
          mcand_r  <= PROD_W'(head_job.square_sum);
          mplier_r <= SUM_W'(head_job.frames);
          cnt_r    <= 5'(FRM_W - 1);
        end
      end
      B_MUL_A: begin
        if (cnt_r == '0) begin
          p1_r     <= acc_add;
          acc_r    <= '0;
          mcand_r  <= PROD_W'(job_r.sample_sum);
          mplier_r <= job_r.sample_sum;
          cnt_r    <= 5'(SUM_W - 1);
        end else begin
          acc_r    <= acc_add;
          mcand_r  <= mcand_r << 1;
          mplier_r <= mplier_r >> 1;
          cnt_r    <= cnt_r - 5'd1;
        end
      end
      B_MUL_B: begin
        acc_r    <= acc_add;
        mcand_r  <= mcand_r << 1;
        mplier_r <= mplier_r >> 1;
        cnt_r    <= cnt_r - 5'd1;
        if (cnt_r == '0) v_r <= (p1_r >= acc_add) ? p1_r - acc_add : '0;
      end
      B_DIV_MEAN: begin
        if (div_done) mean_r <= div_q[RES_W-1:0];
      end
      B_DIV_VAR: begin
        if (div_done) begin
          sq_rem_r <= div_q[X_W-1:0];
          sq_res_r <= '0;
          sq_bit_r <= X_W'(1) << (X_W - 2);
          cnt_r    <= 5'(X_W/2 - 1);
        end
      end
      B_SQRT: begin
        if (sq_fit) sq_rem_r <= sq_rem_r - sq_try;
        sq_res_r <= sq_res_next;
        sq_bit_r <= sq_bit_r >> 2;
        cnt_r    <= cnt_r - 5'd1;
        if (cnt_r == '0) begin
          rms_r <= rms_now;
          avg_r <= '0;
        end
      end
      B_DIV_AVG: begin
        if (div_done) avg_r <= div_q[RES_W-1:0];
      end
      B_OUT: begin
        if (out_free) begin
          out_channel_index   <= job_r.channel;
          out_pixel_index     <= job_r.pixel;
          out_mean_value      <= mean_r;
          out_rms_value       <= rms_r;
          out_channel_done    <= job_r.chan_done;
          out_channel_avg_rms <= avg_r;
        end
      end
      default: cnt_r <= cnt_r;
    endcase
  end

  assign out_empty = !out_valid_r;

  a_sqrt_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_SQRT) |-> $onehot(sq_bit_r)) else $error("sqrt bit not one-hot");
  a_avg_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_channel_done) |-> (out_channel_avg_rms == '0))
    else $error("average on a pixel that does not close its channel");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> (state_r == B_IDLE && !fifo_status.empty))
    else $error("request taken from queue outside idle");

endmodule
`default_nettype wire

>>> sv/pixel_pedestal_mean_rms.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_pedestal_mean_rms
// per-pixel pedestal mean and rms with per-channel average rms
//
// samples enter on in_push/in_full, ordered channel, pixel, frame. the front
// end sums samples and squares at one request per clock while the queue is
// not full; on a pixel's last frame it queues the pixel (4 deep). the back
// end takes one pixel at a time: two shift-add multiplies, a divide for the
// mean, another for the variance, a square root and, on a channel's last
// pixel, a third divide for the average, all divides on the shared divider.
// results wait in an output register, read with out_empty/out_pop; while it
// is held the back end stalls and the queue fills, after which in_full rises.
// reset (synchronous, rst_n low) clears counters, sums and queues and sets
// all three registers to 1. configuration writes (cfg_wr_en) are registered,
// no wait.
// ----------------------------------------------------------------------------
module pixel_pedestal_mean_rms #(
  parameter int MAX_CHANNELS = 8,
  parameter int MAX_FRAMES   = 4096,
  parameter int SAMPLE_BITS  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [ppmr_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [ppmr_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic [ppmr_pkg::SAMPLE_W-1:0] in_sample,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [ppmr_pkg::CH_W-1:0]          out_channel_index,
  output logic [15:0]                        out_pixel_index,
  output logic [ppmr_pkg::RES_W-1:0]         out_mean_value,
  output logic [ppmr_pkg::RES_W-1:0]         out_rms_value,
  output logic                               out_channel_done,
  output logic [ppmr_pkg::RES_W-1:0]         out_channel_avg_rms
);

  import ppmr_pkg::*;

  job_t         push_job, head_job;
  logic         job_push, job_pop;
  fifo_status_t fifo_status;

  ppmr_front #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_FRAMES   (MAX_FRAMES),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_push     (in_push),
    .in_sample   (in_sample),
    .fifo_status (fifo_status),
    .in_full     (in_full),
    .job_push    (job_push),
    .job         (push_job)
  );

  ppmr_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .status   (fifo_status)
  );

  ppmr_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .head_job            (head_job),
    .fifo_status         (fifo_status),
    .job_pop             (job_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_channel_index   (out_channel_index),
    .out_pixel_index     (out_pixel_index),
    .out_mean_value      (out_mean_value),
    .out_rms_value       (out_rms_value),
    .out_channel_done    (out_channel_done),
    .out_channel_avg_rms (out_channel_avg_rms)
  );

endmodule
`default_nettype wire

>>> tb/pixel_pedestal_mean_rms_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_pedestal_mean_rms_tb
// self-checking bench for the pixel pedestal mean/rms block
//
// samples are pushed through the in_ queue port with random gaps, results are
// popped with random stalls. a scoreboard class tracks the accumulators and
// counters of the block, predicts each finished pixel and compares it field
// by field with what comes out. registers change between phases while idle,
// including zero and oversized values and changes in the middle of a pixel.
// ----------------------------------------------------------------------------

typedef struct packed {
  logic [2:0]  chan;
  logic [15:0] pixel;
  logic [23:0] mean;
  logic [23:0] rms;
  logic        done;
  logic [23:0] avg;
} pixel_result_t;

class pedestal_scoreboard;
  logic [12:0] frames_reg;
  logic [16:0] pixels_reg;
  logic [3:0]  chans_reg;
  logic [27:0] sum_acc;
  logic [43:0] sq_acc;
  logic [12:0] frame_cnt;
  logic [16:0] pixel_cnt;
  logic [2:0]  chan_cnt;
  logic [40:0] rms_acc;
  pixel_result_t pending_q[$];
  int errors;
  int results_seen;
  int chans_closed;

  function new();
    frames_reg = 1; pixels_reg = 1; chans_reg = 1;
    sum_acc = 0; sq_acc = 0; frame_cnt = 0; pixel_cnt = 0;
    chan_cnt = 0; rms_acc = 0; errors = 0; results_seen = 0; chans_closed = 0;
  endfunction

  function void set_reg(ppmr_pkg::reg_index_t idx, logic [16:0] val);
    case (idx)
      ppmr_pkg::REG_FRAMES:   frames_reg = val[12:0];
      ppmr_pkg::REG_PIXELS:   pixels_reg = val;
      ppmr_pkg::REG_CHANNELS: chans_reg = val[3:0];
      default: ;
    endcase
  endfunction

  function longint unsigned limit_to(longint unsigned v, longint unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  function void note_sample(logic [15:0] s);
    longint unsigned nf, np, nc, n, n2, nsq, ssq, v, q, r;
    pixel_result_t res;
    nf = limit_to(frames_reg, 4096);
    np = limit_to(pixels_reg, 65536);
    nc = limit_to(chans_reg, 8);
    sum_acc = sum_acc + s;
    sq_acc = sq_acc + 44'(s) * 44'(s);
    if (frame_cnt + 64'd1 < nf) begin
      frame_cnt = frame_cnt + 1;
      return;
    end
    n = frame_cnt + 64'd1;
    res.mean = 24'((64'(sum_acc) << 8) / n);
    nsq = n * sq_acc;
    ssq = 64'(sum_acc) * 64'(sum_acc);
    v = (nsq < ssq) ? 0 : nsq - ssq;
    n2 = n * n;
    q = v / n2;
    r = v % n2;
    res.rms = 24'(int_sqrt((q << 16) + ((r << 16) / n2)));
    res.chan = chan_cnt;
    res.pixel = pixel_cnt[15:0];
    rms_acc = rms_acc + res.rms;
    res.done = (pixel_cnt + 64'd1 >= np);
    res.avg = 0;
    if (res.done) begin
      res.avg = 24'(64'(rms_acc) / np);
      rms_acc = 0;
      pixel_cnt = 0;
      chan_cnt = (chan_cnt + 64'd1 >= nc) ? 3'd0 : chan_cnt + 3'd1;
    end else begin
      pixel_cnt = pixel_cnt + 1;
    end
    sum_acc = 0; sq_acc = 0; frame_cnt = 0;
    pending_q.push_back(res);
  endfunction

  function void check_result(pixel_result_t got);
    pixel_result_t exp_r;
    results_seen++;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result %p", $time, got);
      errors++;
      return;
    end
    exp_r = pending_q.pop_front();
    if (got.done) chans_closed++;
    if (got.chan !== exp_r.chan) begin
      $display("%0t: channel_index exp %0d got %0d", $time, exp_r.chan, got.chan);
      errors++;
    end
    if (got.pixel !== exp_r.pixel) begin
      $display("%0t: pixel_index exp %0d got %0d", $time, exp_r.pixel, got.pixel);
      errors++;
    end
    if (got.mean !== exp_r.mean) begin
      $display("%0t: mean_value exp %h got %h", $time, exp_r.mean, got.mean);
      errors++;
    end
    if (got.rms !== exp_r.rms) begin
      $display("%0t: rms_value exp %h got %h", $time, exp_r.rms, got.rms);
      errors++;
    end
    if (got.done !== exp_r.done) begin
      $display("%0t: channel_done exp %b got %b", $time, exp_r.done, got.done);
      errors++;
    end
    if (got.avg !== exp_r.avg) begin
      $display("%0t: channel_avg_rms exp %h got %h", $time, exp_r.avg, got.avg);
      errors++;
    end
  endfunction
endclass

module pixel_pedestal_mean_rms_tb;
  import ppmr_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  reg_index_t cfg_index = REG_FRAMES;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_push = 0;
  logic in_full;
  logic [SAMPLE_W-1:0] in_sample = '0;
  logic out_empty;
  logic out_pop = 0;
  logic [CH_W-1:0] out_channel_index;
  logic [15:0] out_pixel_index;
  logic [RES_W-1:0] out_mean_value, out_rms_value, out_channel_avg_rms;
  logic out_channel_done;

  pedestal_scoreboard sb = new();
  int samples_sent = 0;
  int pop_stall = 0;
  bit eager = 0;

  pixel_pedestal_mean_rms dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_channel_index(out_channel_index), .out_pixel_index(out_pixel_index),
    .out_mean_value(out_mean_value), .out_rms_value(out_rms_value),
    .out_channel_done(out_channel_done), .out_channel_avg_rms(out_channel_avg_rms)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("[pixel_pedestal_mean_rms] ERROR");
    $finish;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (eager || p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(80, 20);
  endfunction

  // result side: check at the edge, then pick the next pop
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty)
      sb.check_result('{out_channel_index, out_pixel_index, out_mean_value,
                        out_rms_value, out_channel_done, out_channel_avg_rms});
    if (pop_stall > 0) begin
      pop_stall <= pop_stall - 1;
      out_pop <= 0;
    end else if (gap_len() == 0) begin
      out_pop <= 1;
    end else begin
      pop_stall <= gap_len();
      out_pop <= 0;
    end
  end

  task automatic push_sample(logic [15:0] s);
    int g;
    in_push <= 1;
    in_sample <= s;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_sample(s);
    samples_sent++;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  // wait for every pending result plus the back end's worst pixel time
  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (1500) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t idx, logic [16:0] val);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_regs(logic [16:0] f, logic [16:0] p, logic [16:0] c);
    drain();
    cfg_write(REG_FRAMES, f);
    cfg_write(REG_PIXELS, p);
    cfg_write(REG_CHANNELS, c);
    if ($urandom_range(3) == 0) cfg_write(REG_UNUSED, 17'($urandom));
    cfg_wr_en <= 0;
  endtask

  function automatic logic [15:0] rand_sample(int mode, logic [15:0] base);
    case (mode)
      0: return 16'($urandom);
      1: return base + 16'($urandom_range(15)) - 16'd8;
      default: return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
    endcase
  endfunction

  initial begin
    int k, cnt, mode, random_sent;
    logic [15:0] base;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // reset settings: every sample is its own pixel
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'hAAAA);
    push_sample(16'h5555);
    set_regs(2, 3, 2);
    push_sample(16'hFFFF); push_sample(16'h0000);
    push_sample(16'hFFFF); push_sample(16'hFFFF);
    push_sample(16'h0000); push_sample(16'h0000);
    push_sample(16'h1234); push_sample(16'h1235);
    push_sample(16'h8000);
    // zero registers act as one; this also changes settings mid pixel
    set_regs(0, 0, 0);
    push_sample(16'h0001); push_sample(16'h7FFF);
    set_regs(3, 131071, 8);
    for (k = 0; k < 12; k++) push_sample(rand_sample(2, 0));
    set_regs(3, 65536, 15);
    for (k = 0; k < 7; k++) push_sample(16'($urandom));
    // oversized frame setting, alternating extremes for the widest spread
    set_regs(8191, 1, 1);
    eager = 1;
    for (k = 0; k < 512; k++) push_sample(k[0] ? 16'hFFFF : 16'h0000);
    eager = 0;
    // a smaller frame setting closes the long pixel on the next sample
    set_regs(1, 2, 3);
    push_sample(16'hFFFF);

    random_sent = 0;
    while (random_sent < 560) begin
      set_regs(($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1),
               ($urandom_range(9) == 0) ? ($urandom_range(1) ? 0 : 65536)
                                        : $urandom_range(5, 1),
               $urandom_range(15));
      eager = ($urandom_range(4) == 0);
      mode = $urandom_range(2);
      base = 16'($urandom);
      cnt = $urandom_range(50, 20);
      for (k = 0; k < cnt; k++) push_sample(rand_sample(mode, base));
      random_sent += cnt;
    end
    eager = 0;
    drain();

    $display("run covered %0d samples, %0d pixel results, %0d channel closes",
             samples_sent, sb.results_seen, sb.chans_closed);
    $display("settings swept frames 0..8191, pixels 0..131071, channels 0..15");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[pixel_pedestal_mean_rms] OK");
    end else begin
      $display("[pixel_pedestal_mean_rms] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
sv/ppmr_pkg.sv
sv/ppmr_div.sv
sv/ppmr_fifo.sv
sv/ppmr_front.sv
sv/ppmr_back.sv
sv/pixel_pedestal_mean_rms.sv
tb/pixel_pedestal_mean_rms_tb.sv
